[rtl/core/tcf_pkg.sv]
package tcf_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    typedef enum logic [1:0] {
        ACT_ENQ     = 2'd0,
        ACT_DEQ_ANY = 2'd1,
        ACT_DEQ_K0  = 2'd2,
        ACT_DEQ_K1  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DELIVERED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

[rtl/core/two_class_fifo_oldest_first_unit.sv]
// an accepted item is captured with both queue heads, then executed into the output register
// capture and execute steps alternate, so a new item is taken only once the last has executed
// the output register lets the next item be accepted while a result waits on m_tready
// reset: aresetn synchronous, active low; clears queue pointers, fill counts and the stamp
// counter; the entry stores are not cleared
module two_class_fifo_oldest_first_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcf_pkg::S_DATA_W-1:0]   s_tdata,   // action, item_tag, zero pad
    input  logic                           s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcf_pkg::M_DATA_W-1:0]   m_tdata,   // status, out_tag, zero pad
    output logic                           m_tuser    // out_kind
);

    tcf_pkg::cmd_t                 cmd;
    logic [1:0]                    out_status;
    logic [tcf_pkg::TAG_W-1:0]     out_tag;

    tcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcf_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_action  (s_tdata[1:0]),
        .in_kind    (s_tuser),
        .in_tag     (s_tdata[tcf_pkg::TAG_W+1:2]),
        .out_status (out_status),
        .out_tag    (out_tag),
        .out_kind   (m_tuser)
    );

    assign m_tdata = {{(tcf_pkg::M_DATA_W - tcf_pkg::TAG_W - 2){1'b0}}, out_tag, out_status};

endmodule

[rtl/core/tcf_ctrl.sv]
module tcf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output tcf_pkg::cmd_t cmd
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.capture   = 1'b0;
        cmd.execute   = 1'b0;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = EXEC;
                end
            end
            EXEC: begin
                if (out_free) begin
                    cmd.execute   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/core/tcf_datapath.sv]
module tcf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcf_pkg::cmd_t                 cmd,
    input  logic [1:0]                    in_action,
    input  logic                          in_kind,
    input  logic [tcf_pkg::TAG_W-1:0]     in_tag,
    output logic [1:0]                    out_status,
    output logic [tcf_pkg::TAG_W-1:0]     out_tag,
    output logic                          out_kind
);

    tcf_pkg::entry_t mem0 [tcf_pkg::DEPTH];
    tcf_pkg::entry_t mem1 [tcf_pkg::DEPTH];

    tcf_pkg::action_t              action_reg;
    logic                          kind_reg;
    logic [tcf_pkg::TAG_W-1:0]     tag_reg;
    tcf_pkg::entry_t               hd0_reg, hd1_reg;

    logic [tcf_pkg::PTR_W-1:0]     head0_reg, head1_reg, tail0_reg, tail1_reg;
    logic [tcf_pkg::CNT_W-1:0]     cnt0_reg, cnt1_reg;
    logic [tcf_pkg::STAMP_W-1:0]   stamp_cnt_reg;

    tcf_pkg::status_t              status_reg, status_next;
    logic [tcf_pkg::TAG_W-1:0]     otag_reg, otag_next;
    logic                          okind_reg, okind_next;

    logic                          empty0, empty1, full0, full1;
    logic                          wr0, wr1, pop0, pop1;
    logic [tcf_pkg::STAMP_W-1:0]   stamp_diff;

    function automatic logic [tcf_pkg::PTR_W-1:0] adv(input logic [tcf_pkg::PTR_W-1:0] p);
        logic [tcf_pkg::PTR_W-1:0] r;
        if (p == tcf_pkg::PTR_W'(tcf_pkg::DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign empty0     = (cnt0_reg == '0);
    assign empty1     = (cnt1_reg == '0);
    assign full0      = (cnt0_reg == tcf_pkg::CNT_W'(tcf_pkg::DEPTH));
    assign full1      = (cnt1_reg == tcf_pkg::CNT_W'(tcf_pkg::DEPTH));
    assign stamp_diff = hd1_reg.stamp - hd0_reg.stamp;

    always_comb begin
        wr0         = 1'b0;
        wr1         = 1'b0;
        pop0        = 1'b0;
        pop1        = 1'b0;
        status_next = tcf_pkg::ST_EMPTY;
        okind_next  = 1'b0;
        case (action_reg)
            tcf_pkg::ACT_ENQ: begin
                okind_next = kind_reg;
                if (kind_reg ? full1 : full0) begin
                    status_next = tcf_pkg::ST_FULL;
                end else begin
                    status_next = tcf_pkg::ST_ENQUEUED;
                    wr0         = !kind_reg;
                    wr1         = kind_reg;
                end
            end
            tcf_pkg::ACT_DEQ_K0: begin
                pop0 = !empty0;
            end
            tcf_pkg::ACT_DEQ_K1: begin
                okind_next = 1'b1;
                pop1       = !empty1;
            end
            tcf_pkg::ACT_DEQ_ANY: begin
                if (empty0) begin
                    pop1 = !empty1;
                end else if (empty1) begin
                    pop0 = 1'b1;
                end else begin
                    pop1 = stamp_diff[tcf_pkg::STAMP_W-1];
                    pop0 = !stamp_diff[tcf_pkg::STAMP_W-1];
                end
            end
            default: begin
                status_next = tcf_pkg::ST_EMPTY;
            end
        endcase
        otag_next = '0;
        if (pop0) begin
            status_next = tcf_pkg::ST_DELIVERED;
            otag_next   = hd0_reg.tag;
            okind_next  = 1'b0;
        end else if (pop1) begin
            status_next = tcf_pkg::ST_DELIVERED;
            otag_next   = hd1_reg.tag;
            okind_next  = 1'b1;
        end
    end

    // item capture and head read
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= tcf_pkg::action_t'(in_action);
            kind_reg   <= in_kind;
            tag_reg    <= in_tag;
            hd0_reg    <= mem0[head0_reg];
            hd1_reg    <= mem1[head1_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && wr0) begin
            mem0[tail0_reg] <= '{tag: tag_reg, stamp: stamp_cnt_reg};
        end
        if (cmd.execute && wr1) begin
            mem1[tail1_reg] <= '{tag: tag_reg, stamp: stamp_cnt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head0_reg     <= '0;
            head1_reg     <= '0;
            tail0_reg     <= '0;
            tail1_reg     <= '0;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            stamp_cnt_reg <= '0;
        end else if (cmd.execute) begin
            if (wr0) begin
                tail0_reg <= adv(tail0_reg);
                cnt0_reg  <= cnt0_reg + 1'b1;
            end
            if (wr1) begin
                tail1_reg <= adv(tail1_reg);
                cnt1_reg  <= cnt1_reg + 1'b1;
            end
            if (wr0 || wr1) begin
                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
            end
            if (pop0) begin
                head0_reg <= adv(head0_reg);
                cnt0_reg  <= cnt0_reg - 1'b1;
            end
            if (pop1) begin
                head1_reg <= adv(head1_reg);
                cnt1_reg  <= cnt1_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg <= status_next;
            otag_reg   <= otag_next;
            okind_reg  <= okind_next;
        end
    end

    assign out_status = status_reg;
    assign out_tag    = otag_reg;
    assign out_kind   = okind_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PAD_W       = S_DATA_W - TAG_W - 2;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic             kind;
    } outcome_t;

    typedef struct {
        action_t          act;
        logic             kind;
        logic [TAG_W-1:0] tag;
        logic             typed;
        outcome_t         res;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    two_class_fifo_oldest_first_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // action, item_tag, zero pad
        .s_tuser  (s_tuser),   // kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // status, out_tag, zero pad
        .m_tuser  (m_tuser)    // out_kind
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // queue model state
    logic [TAG_W-1:0]   q_tag   [2][DEPTH];
    logic [STAMP_W-1:0] q_stamp [2][DEPTH];
    logic [PTR_W-1:0]   q_head  [2];
    logic [PTR_W-1:0]   q_tail  [2];
    logic [CNT_W-1:0]   q_count [2];
    logic [STAMP_W-1:0] stamp_ctr;

    outcome_t pending_q [$];
    dir_row_t dir_rows  [$];

    int errors      = 0;
    int cycle_cnt   = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int n_enq       = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_deliv     = 0;
    int n_k1_older  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic outcome_t pop_head(logic k);
        outcome_t r;
        r.status   = ST_DELIVERED;
        r.tag      = q_tag[k][q_head[k]];
        r.kind     = k;
        q_head[k]  = next_ptr(q_head[k]);
        q_count[k] = q_count[k] - 1'b1;
        n_deliv++;
        return r;
    endfunction

    function automatic outcome_t predict_outcome(action_t act, logic k, logic [TAG_W-1:0] t);
        outcome_t           r;
        logic               sel;
        logic [STAMP_W-1:0] d;
        r.status = ST_EMPTY;
        r.tag    = '0;
        r.kind   = 1'b0;
        case (act)
            ACT_ENQ: begin
                r.kind = k;
                if (q_count[k] == CNT_W'(DEPTH)) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    q_tag[k][q_tail[k]]   = t;
                    q_stamp[k][q_tail[k]] = stamp_ctr;
                    q_tail[k]  = next_ptr(q_tail[k]);
                    q_count[k] = q_count[k] + 1'b1;
                    stamp_ctr  = stamp_ctr + 1'b1;
                    r.status   = ST_ENQUEUED;
                    n_enq++;
                end
            end
            ACT_DEQ_K0, ACT_DEQ_K1: begin
                sel    = (act == ACT_DEQ_K1);
                r.kind = sel;
                if (q_count[sel] != 0) r = pop_head(sel);
                else n_empty++;
            end
            default: begin
                if (q_count[0] == 0 && q_count[1] == 0) begin
                    n_empty++;
                end else begin
                    if (q_count[0] == 0) begin
                        sel = 1'b1;
                    end else if (q_count[1] == 0) begin
                        sel = 1'b0;
                    end else begin
                        d   = q_stamp[1][q_head[1]] - q_stamp[0][q_head[0]];
                        sel = d[STAMP_W-1];
                        if (sel) n_k1_older++;
                    end
                    r = pop_head(sel);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input action_t act, input logic k, input logic [TAG_W-1:0] t,
                             input logic typed, input outcome_t typed_res);
        int       gap;
        outcome_t r;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, t, act};
        s_tuser  <= k;
        do @(posedge aclk); while (!s_tready);
        r = predict_outcome(act, k, t);
        pending_q.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_q.size() != 0);
    endtask

    function automatic void add_row(action_t act, logic k, logic [TAG_W-1:0] t,
                                    logic typed, status_t st, logic ok);
        dir_row_t row;
        row.act        = act;
        row.kind       = k;
        row.tag        = t;
        row.typed      = typed;
        row.res.status = st;
        row.res.tag    = '0;
        row.res.kind   = ok;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        add_row(ACT_DEQ_ANY, 1'b0, 16'h0000, 1'b1, ST_EMPTY, 1'b0);
        add_row(ACT_DEQ_K0,  1'b1, 16'hFFFF, 1'b1, ST_EMPTY, 1'b0);
        add_row(ACT_DEQ_K1,  1'b0, 16'h0000, 1'b1, ST_EMPTY, 1'b1);
        add_row(ACT_ENQ,     1'b0, 16'hFFFF, 1'b1, ST_ENQUEUED, 1'b0);
        for (int i = 0; i < DEPTH - 1; i++)
            add_row(ACT_ENQ, 1'b0, TAG_W'(1) << i, 1'b1, ST_ENQUEUED, 1'b0);
        add_row(ACT_ENQ,     1'b0, 16'h1234, 1'b1, ST_FULL, 1'b0);
        add_row(ACT_ENQ,     1'b1, 16'h0000, 1'b1, ST_ENQUEUED, 1'b1);
        add_row(ACT_DEQ_ANY, 1'b1, 16'h5A5A, 1'b0, ST_EMPTY, 1'b0);
        add_row(ACT_DEQ_K1,  1'b0, 16'hA5A5, 1'b0, ST_EMPTY, 1'b0);
        add_row(ACT_DEQ_K1,  1'b1, 16'hFFFF, 1'b1, ST_EMPTY, 1'b1);
        add_row(ACT_DEQ_K0,  1'b0, 16'h0000, 1'b0, ST_EMPTY, 1'b0);
    endfunction

    task automatic random_traffic(input int n_items);
        int               seg_left;
        int               enq_pct;
        int               k1_pct;
        int               pick;
        action_t          act;
        logic             k;
        logic [TAG_W-1:0] t;
        seg_left = 0;
        enq_pct  = 50;
        k1_pct   = 50;
        for (int i = 0; i < n_items; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0: enq_pct = 15;
                    1: enq_pct = 35;
                    2: enq_pct = 50;
                    3: enq_pct = 65;
                    default: enq_pct = 85;
                endcase
                case ($urandom_range(0, 2))
                    0: k1_pct = 10;
                    1: k1_pct = 50;
                    default: k1_pct = 90;
                endcase
            end
            seg_left--;
            k = ($urandom_range(0, 99) < k1_pct);
            pick = $urandom_range(0, 9);
            t = (pick == 0) ? '0 : (pick == 1) ? '1 : TAG_W'($urandom);
            if ($urandom_range(0, 99) < enq_pct) begin
                act = ACT_ENQ;
            end else begin
                pick = $urandom_range(0, 3);
                act  = (pick < 2) ? ACT_DEQ_ANY : (pick == 2) ? ACT_DEQ_K0 : ACT_DEQ_K1;
            end
            send_item(act, k, t, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        outcome_t got;
        outcome_t want;
        got.status = status_t'(m_tdata[1:0]);
        got.tag    = m_tdata[TAG_W+1:2];
        got.kind   = m_tuser;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d tag %h kind %0d",
                         $time, got.status, got.tag, got.kind);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected st %0d tag %h kind %0d, got st %0d tag %h kind %0d",
                             $time, want.status, want.tag, want.kind,
                             got.status, got.tag, got.kind);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ~m_tready;
            2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        stamp_ctr = '0;
        for (int k = 0; k < 2; k++) begin
            q_head[k]  = '0;
            q_tail[k]  = '0;
            q_count[k] = '0;
        end
        build_directed();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].kind, dir_rows[i].tag,
                      dir_rows[i].typed, dir_rows[i].res);
        wait_drained();

        for (int seg = 0; seg < 4; seg++) begin
            random_traffic(306);
            wait_drained();
        end
        repeat (8) @(posedge aclk);

        $display("covered %0d items: %0d enqueued, %0d rejected on full, %0d delivered",
                 items_sent, n_enq, n_full, n_deliv);
        $display("%0d empty dequeues, %0d oldest-first picks of the second kind",
                 n_empty, n_k1_older);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
